### hdl/qtd_pkg.sv
// ============================================================================
// Quad SPI transaction decoder package
// Shared types, codes and constants for the decoder, its result side, checker and bench.
// ============================================================================
package qtd_pkg;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_SKIP  = 3'd1,
        PH_IDLE  = 3'd2,
        PH_CMD   = 3'd3,
        PH_ADDR  = 3'd4,
        PH_DUMMY = 3'd5,
        PH_DATA  = 3'd6,
        PH_HOLD  = 3'd7
    } phase_t;

    localparam logic [2:0] KIND_ENABLE  = 3'd0;
    localparam logic [2:0] KIND_COMMAND = 3'd1;
    localparam logic [2:0] KIND_ADDRESS = 3'd2;
    localparam logic [2:0] KIND_DUMMY   = 3'd3;
    localparam logic [2:0] KIND_DATA    = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;
    localparam logic [2:0] KIND_DISABLE = 3'd6;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CLK_ACTIVE = 3'd1;
    localparam logic [2:0] ERR_TRUNC_CMD  = 3'd2;
    localparam logic [2:0] ERR_TRUNC_ADDR = 3'd3;
    localparam logic [2:0] ERR_TRUNC_DUMMY = 3'd4;
    localparam logic [2:0] ERR_TRUNC_DATA = 3'd5;

    localparam logic [2:0] REG_CS_ACTIVE    = 3'd0;
    localparam logic [2:0] REG_CLK_IDLE     = 3'd1;
    localparam logic [2:0] REG_TRAILING     = 3'd2;
    localparam logic [2:0] REG_CMD_LANES    = 3'd3;
    localparam logic [2:0] REG_ADDR_BITS    = 3'd4;
    localparam logic [2:0] REG_ADDR_LANES   = 3'd5;
    localparam logic [2:0] REG_DUMMY_CYCLES = 3'd6;
    localparam logic [2:0] REG_DATA_LANES   = 3'd7;

    localparam logic [1:0] LANES_1 = 2'd0;
    localparam logic [1:0] LANES_2 = 2'd1;

    localparam logic [5:0] WORD_BITS       = 6'd8;
    localparam logic [5:0] ADDR_BITS_RESET = 6'd24;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  code;
        logic [31:0] value;
        logic [7:0]  io1;
        logic [5:0]  bits;
    } frame_t;

    function automatic logic [5:0] lane_count(input logic [1:0] code);
        case (code)
            LANES_1: lane_count = 6'd1;
            LANES_2: lane_count = 6'd2;
            default: lane_count = 6'd4;
        endcase
    endfunction

endpackage

### hdl/qspi_transaction_decoder.sv
// ============================================================================
// Quad SPI transaction decoder
// Decodes enable, command, address, dummy, data, error and disable frames from
// an oversampled stream of chip select, clock and IO0-3 snapshots.
// ============================================================================
// Frames of a snapshot are written to the batch queue and shown from its head in order.
// Throughput: one snapshot per cycle while full is low; a snapshot yields zero, one or two
//   frames, each taken by one pop: the result side sets the pace when most yield frames.
// full rises when the batch queue holds QUEUE_DEPTH snapshots with frames still pending.
// Reset: registers take their defaults, the queue empties, decoding waits for a first sample.
module qspi_transaction_decoder #(
    parameter int ADDRESS_MAX_BITS = 32,
    parameter int TIME_BITS        = 48,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [5:0]           cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 cs_level,
    input  logic                 clk_level,
    input  logic [3:0]           io_levels,
    output logic                 empty,
    input  logic                 pop,
    output logic [2:0]           frame_kind,
    output logic [2:0]           error_code,
    output logic [31:0]          frame_value,
    output logic [7:0]           io1_byte,
    output logic [5:0]           bits_captured,
    output logic [TIME_BITS-1:0] start_time,
    output logic [TIME_BITS-1:0] end_time,
    output logic                 last_of_run
);

    localparam int BATCH_BITS = 2 + 2 * $bits(qtd_pkg::frame_t) + 4 * TIME_BITS;

    logic                      accept;
    logic                      b_valid;
    logic [1:0]                b_count;
    qtd_pkg::frame_t [1:0]     b_frame;
    logic [1:0][TIME_BITS-1:0] b_start;
    logic [1:0][TIME_BITS-1:0] b_end;
    logic [BATCH_BITS-1:0]     q_wdata;
    logic [BATCH_BITS-1:0]     q_rdata;
    logic                      q_empty;
    logic                      q_release;
    logic [1:0]                h_count;
    qtd_pkg::frame_t [1:0]     h_frame;
    logic [1:0][TIME_BITS-1:0] h_start;
    logic [1:0][TIME_BITS-1:0] h_end;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign q_wdata   = {b_count, b_frame, b_start, b_end};
    assign {h_count, h_frame, h_start, h_end} = q_rdata;

    qtd_front #(
        .ADDRESS_MAX_BITS (ADDRESS_MAX_BITS),
        .TIME_BITS        (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .cs_level    (cs_level),
        .clk_level   (clk_level),
        .io_levels   (io_levels),
        .batch_valid (b_valid),
        .batch_count (b_count),
        .batch_frame (b_frame),
        .batch_start (b_start),
        .batch_end   (b_end)
    );

    qtd_queue #(
        .WIDTH (BATCH_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_valid),
        .wr_data (q_wdata),
        .rd_en   (q_release),
        .rd_data (q_rdata),
        .full    (full),
        .empty   (q_empty)
    );

    qtd_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!q_empty),
        .head_count    (h_count),
        .head_frame    (h_frame),
        .head_start    (h_start),
        .head_end      (h_end),
        .pop           (pop),
        .head_release  (q_release),
        .empty         (empty),
        .frame_kind    (frame_kind),
        .error_code    (error_code),
        .frame_value   (frame_value),
        .io1_byte      (io1_byte),
        .bits_captured (bits_captured),
        .start_time    (start_time),
        .end_time      (end_time),
        .last_of_run   (last_of_run)
    );

endmodule

### hdl/qtd_front.sv
// ============================================================================
// Quad SPI decoder front end
// Holds the configuration and decoding state, classifies each line snapshot
// and forms the batch of frames that the snapshot produces.
// ============================================================================
module qtd_front #(
    parameter int ADDRESS_MAX_BITS = 32,
    parameter int TIME_BITS        = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [2:0]                      cfg_index,
    input  logic [5:0]                      cfg_data,
    input  logic                            accept,
    input  logic                            cs_level,
    input  logic                            clk_level,
    input  logic [3:0]                      io_levels,
    output logic                            batch_valid,
    output logic [1:0]                      batch_count,
    output qtd_pkg::frame_t [1:0]           batch_frame,
    output logic [1:0][TIME_BITS-1:0]       batch_start,
    output logic [1:0][TIME_BITS-1:0]       batch_end
);

    logic                   cs_active_reg;
    logic                   clk_idle_reg;
    logic                   trailing_reg;
    logic [1:0]             cmd_lanes_reg;
    logic [5:0]             addr_bits_reg;
    logic [1:0]             addr_lanes_reg;
    logic [4:0]             dummy_reg;
    logic [1:0]             data_lanes_reg;

    qtd_pkg::phase_t        phase_reg, phase_next;
    logic                   prev_cs_reg, prev_cs_next;
    logic                   prev_clk_reg, prev_clk_next;
    logic [31:0]            shift_reg, shift_next;
    logic [7:0]             io1_reg, io1_next;
    logic [5:0]             bit_cnt_reg, bit_cnt_next;
    logic [5:0]             edge_cnt_reg, edge_cnt_next;
    logic [TIME_BITS-1:0]   cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]   cnt_p1_reg, cnt_p1_next;
    logic [TIME_BITS-1:0]   first_reg, first_next;
    logic [TIME_BITS-1:0]   first_p1_reg, first_p1_next;
    logic [TIME_BITS-1:0]   last_reg, last_next;

    logic                   cs_edge;
    logic                   clk_edge;
    logic [1:0]             lane_code;
    logic [5:0]             lanes;
    logic [5:0]             addr_sat;
    logic [5:0]             addr_tgt;
    logic [5:0]             target;
    logic                   half;
    logic                   sample_hit;
    logic [5:0]             edge_inc;
    logic [31:0]            shifted;
    logic                   upd;
    logic                   new_first;
    logic [TIME_BITS-1:0]   sel_first;
    logic [TIME_BITS-1:0]   sel_first_p1;
    logic [TIME_BITS-1:0]   sel_last;
    logic [TIME_BITS-1:0]   frame_end;
    logic [2:0]             word_kind;
    logic [2:0]             word_err;
    logic                   full_word;
    logic                   do_enter;
    qtd_pkg::phase_t        enter_phase;
    logic [1:0]             nres;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_active_reg  <= 1'b0;
            clk_idle_reg   <= 1'b0;
            trailing_reg   <= 1'b0;
            cmd_lanes_reg  <= qtd_pkg::LANES_1;
            addr_bits_reg  <= qtd_pkg::ADDR_BITS_RESET;
            addr_lanes_reg <= qtd_pkg::LANES_1;
            dummy_reg      <= 5'd0;
            data_lanes_reg <= qtd_pkg::LANES_1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qtd_pkg::REG_CS_ACTIVE:    cs_active_reg  <= cfg_data[0];
                qtd_pkg::REG_CLK_IDLE:     clk_idle_reg   <= cfg_data[0];
                qtd_pkg::REG_TRAILING:     trailing_reg   <= cfg_data[0];
                qtd_pkg::REG_CMD_LANES:    cmd_lanes_reg  <= cfg_data[1:0];
                qtd_pkg::REG_ADDR_BITS:    addr_bits_reg  <= cfg_data;
                qtd_pkg::REG_ADDR_LANES:   addr_lanes_reg <= cfg_data[1:0];
                qtd_pkg::REG_DUMMY_CYCLES: dummy_reg      <= cfg_data[4:0];
                qtd_pkg::REG_DATA_LANES:   data_lanes_reg <= cfg_data[1:0];
                default:                   data_lanes_reg <= data_lanes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= qtd_pkg::PH_FIRST;
            prev_cs_reg  <= 1'b0;
            prev_clk_reg <= 1'b0;
            shift_reg    <= '0;
            io1_reg      <= '0;
            bit_cnt_reg  <= '0;
            edge_cnt_reg <= '0;
            cnt_reg      <= '0;
            cnt_p1_reg   <= TIME_BITS'(1);
            first_reg    <= '0;
            first_p1_reg <= TIME_BITS'(1);
            last_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            prev_cs_reg  <= prev_cs_next;
            prev_clk_reg <= prev_clk_next;
            shift_reg    <= shift_next;
            io1_reg      <= io1_next;
            bit_cnt_reg  <= bit_cnt_next;
            edge_cnt_reg <= edge_cnt_next;
            cnt_reg      <= cnt_next;
            cnt_p1_reg   <= cnt_p1_next;
            first_reg    <= first_next;
            first_p1_reg <= first_p1_next;
            last_reg     <= last_next;
        end
    end

    always_comb
    begin
        cs_edge  = cs_level != prev_cs_reg;
        clk_edge = clk_level != prev_clk_reg;

        case (phase_reg)
            qtd_pkg::PH_CMD:  lane_code = cmd_lanes_reg;
            qtd_pkg::PH_ADDR: lane_code = addr_lanes_reg;
            default:          lane_code = data_lanes_reg;
        endcase
        lanes = qtd_pkg::lane_count(lane_code);

        addr_sat = (addr_bits_reg > 6'(ADDRESS_MAX_BITS)) ? 6'(ADDRESS_MAX_BITS)
                                                           : addr_bits_reg;
        case (addr_lanes_reg)
            qtd_pkg::LANES_1: addr_tgt = addr_sat;
            qtd_pkg::LANES_2: addr_tgt = {addr_sat[5:1], 1'b0};
            default:          addr_tgt = {addr_sat[5:2], 2'b00};
        endcase
        target = (phase_reg == qtd_pkg::PH_ADDR) ? addr_tgt : qtd_pkg::WORD_BITS;

        half       = edge_cnt_reg[0];
        sample_hit = trailing_reg ? half : !half;
        edge_inc   = edge_cnt_reg + 6'd1;

        case (lane_code)
            qtd_pkg::LANES_1: shifted = {shift_reg[30:0], io_levels[0]};
            qtd_pkg::LANES_2: shifted = {shift_reg[29:0], io_levels[1:0]};
            default:          shifted = {shift_reg[27:0], io_levels};
        endcase

        case (phase_reg)
            qtd_pkg::PH_CMD:
            begin
                word_kind = qtd_pkg::KIND_COMMAND;
                word_err  = qtd_pkg::ERR_TRUNC_CMD;
            end
            qtd_pkg::PH_ADDR:
            begin
                word_kind = qtd_pkg::KIND_ADDRESS;
                word_err  = qtd_pkg::ERR_TRUNC_ADDR;
            end
            default:
            begin
                word_kind = qtd_pkg::KIND_DATA;
                word_err  = qtd_pkg::ERR_TRUNC_DATA;
            end
        endcase

        // Edge time tracking: one compare over the selected first and last times
        if (phase_reg == qtd_pkg::PH_DUMMY)
        begin
            upd       = accept && !cs_edge && clk_edge;
            new_first = edge_inc == 6'd1;
        end
        else if (phase_reg == qtd_pkg::PH_CMD || phase_reg == qtd_pkg::PH_ADDR ||
                 phase_reg == qtd_pkg::PH_DATA)
        begin
            upd       = accept && !cs_edge && clk_edge && sample_hit;
            new_first = bit_cnt_reg == 6'd0;
        end
        else
        begin
            upd       = 1'b0;
            new_first = 1'b0;
        end
        sel_first    = (upd && new_first) ? cnt_reg : first_reg;
        sel_first_p1 = (upd && new_first) ? cnt_p1_reg : first_p1_reg;
        sel_last     = upd ? cnt_reg : last_reg;
        frame_end    = (sel_last > sel_first) ? sel_last : sel_first_p1;

        full_word = !trailing_reg && edge_cnt_reg[0] && (bit_cnt_reg >= target);

        phase_next    = phase_reg;
        prev_cs_next  = prev_cs_reg;
        prev_clk_next = prev_clk_reg;
        shift_next    = shift_reg;
        io1_next      = io1_reg;
        bit_cnt_next  = bit_cnt_reg;
        edge_cnt_next = edge_cnt_reg;
        cnt_next      = cnt_reg;
        cnt_p1_next   = cnt_p1_reg;
        first_next    = sel_first;
        first_p1_next = sel_first_p1;
        last_next     = sel_last;
        do_enter      = 1'b0;
        enter_phase   = qtd_pkg::PH_DATA;
        nres          = 2'd0;
        batch_frame   = '0;
        batch_start   = '0;
        batch_end     = '0;

        if (accept)
        begin
            prev_cs_next  = cs_level;
            prev_clk_next = clk_level;
            cnt_next      = cnt_p1_reg;
            cnt_p1_next   = cnt_p1_reg + TIME_BITS'(1);

            case (phase_reg)
                qtd_pkg::PH_FIRST:
                begin
                    phase_next = (cs_level == cs_active_reg) ? qtd_pkg::PH_SKIP
                                                             : qtd_pkg::PH_IDLE;
                end
                qtd_pkg::PH_SKIP:
                begin
                    if (cs_edge)
                        phase_next = qtd_pkg::PH_IDLE;
                end
                qtd_pkg::PH_IDLE:
                begin
                    if (cs_edge)
                    begin
                        batch_frame[0].kind = qtd_pkg::KIND_ENABLE;
                        batch_start[0]      = cnt_reg;
                        batch_end[0]        = cnt_p1_reg;
                        nres                = 2'd1;
                        if (clk_level != clk_idle_reg)
                        begin
                            batch_frame[1].kind = qtd_pkg::KIND_ERROR;
                            batch_frame[1].code = qtd_pkg::ERR_CLK_ACTIVE;
                            batch_start[1]      = cnt_reg;
                            batch_end[1]        = cnt_p1_reg;
                            nres                = 2'd2;
                            phase_next          = qtd_pkg::PH_HOLD;
                        end
                        else
                        begin
                            do_enter    = 1'b1;
                            enter_phase = qtd_pkg::PH_CMD;
                        end
                    end
                end
                qtd_pkg::PH_HOLD:
                begin
                    if (cs_edge)
                    begin
                        batch_frame[0].kind = qtd_pkg::KIND_DISABLE;
                        batch_start[0]      = cnt_reg;
                        batch_end[0]        = cnt_p1_reg;
                        nres                = 2'd1;
                        phase_next          = qtd_pkg::PH_IDLE;
                    end
                end
                qtd_pkg::PH_DUMMY:
                begin
                    if (cs_edge)
                    begin
                        if (edge_cnt_reg != 6'd0)
                        begin
                            batch_frame[0].kind  = qtd_pkg::KIND_ERROR;
                            batch_frame[0].code  = qtd_pkg::ERR_TRUNC_DUMMY;
                            batch_frame[0].value = {27'd0, dummy_reg};
                            batch_start[0]       = sel_first;
                            batch_end[0]         = frame_end;
                            nres                 = 2'd1;
                        end
                        batch_frame[nres[0]].kind = qtd_pkg::KIND_DISABLE;
                        batch_start[nres[0]]      = cnt_reg;
                        batch_end[nres[0]]        = cnt_p1_reg;
                        nres                      = nres + 2'd1;
                        phase_next                = qtd_pkg::PH_IDLE;
                    end
                    else if (clk_edge)
                    begin
                        edge_cnt_next = edge_inc;
                        if (edge_inc >= {dummy_reg, 1'b0})
                        begin
                            batch_frame[0].kind  = qtd_pkg::KIND_DUMMY;
                            batch_frame[0].value = {27'd0, dummy_reg};
                            batch_start[0]       = sel_first;
                            batch_end[0]         = frame_end;
                            nres                 = 2'd1;
                            do_enter             = 1'b1;
                            enter_phase          = qtd_pkg::PH_DATA;
                        end
                    end
                end
                default:
                begin
                    if (cs_edge)
                    begin
                        if (bit_cnt_reg != 6'd0)
                        begin
                            batch_frame[0].kind  = full_word ? word_kind : qtd_pkg::KIND_ERROR;
                            batch_frame[0].code  = full_word ? qtd_pkg::ERR_NONE : word_err;
                            batch_frame[0].value = shift_reg;
                            batch_frame[0].io1   = (phase_reg == qtd_pkg::PH_DATA) ? io1_reg
                                                                                    : 8'd0;
                            batch_frame[0].bits  = bit_cnt_reg;
                            batch_start[0]       = sel_first;
                            batch_end[0]         = frame_end;
                            nres                 = 2'd1;
                        end
                        batch_frame[nres[0]].kind = qtd_pkg::KIND_DISABLE;
                        batch_start[nres[0]]      = cnt_reg;
                        batch_end[nres[0]]        = cnt_p1_reg;
                        nres                      = nres + 2'd1;
                        phase_next                = qtd_pkg::PH_IDLE;
                    end
                    else if (clk_edge)
                    begin
                        edge_cnt_next = edge_inc;
                        if (sample_hit)
                        begin
                            shift_next   = shifted;
                            bit_cnt_next = bit_cnt_reg + lanes;
                            if (lane_code == qtd_pkg::LANES_1)
                                io1_next = {io1_reg[6:0], io_levels[1]};
                        end
                        if (half && bit_cnt_next >= target)
                        begin
                            if (bit_cnt_next != 6'd0)
                            begin
                                batch_frame[0].kind  = word_kind;
                                batch_frame[0].value = shift_next;
                                batch_frame[0].io1   = (phase_reg == qtd_pkg::PH_DATA)
                                                       ? io1_next : 8'd0;
                                batch_frame[0].bits  = bit_cnt_next;
                                batch_start[0]       = sel_first;
                                batch_end[0]         = frame_end;
                                nres                 = 2'd1;
                            end
                            do_enter = 1'b1;
                            if (phase_reg == qtd_pkg::PH_CMD)
                            begin
                                if (addr_tgt != 6'd0)
                                    enter_phase = qtd_pkg::PH_ADDR;
                                else if (dummy_reg != 5'd0)
                                    enter_phase = qtd_pkg::PH_DUMMY;
                                else
                                    enter_phase = qtd_pkg::PH_DATA;
                            end
                            else if (phase_reg == qtd_pkg::PH_ADDR)
                            begin
                                enter_phase = (dummy_reg != 5'd0) ? qtd_pkg::PH_DUMMY
                                                                  : qtd_pkg::PH_DATA;
                            end
                            else
                            begin
                                enter_phase = qtd_pkg::PH_DATA;
                            end
                        end
                    end
                end
            endcase

            if (do_enter)
            begin
                phase_next    = enter_phase;
                shift_next    = '0;
                io1_next      = '0;
                bit_cnt_next  = '0;
                edge_cnt_next = '0;
            end
        end

        batch_valid = accept && (nres != 2'd0);
        batch_count = nres;
    end

endmodule

### hdl/qtd_queue.sv
// ============================================================================
// Quad SPI decoder batch queue
// Short first-in first-out store of frame batches between the two halves.
// ============================================================================
module qtd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    store_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    always_comb
    begin
        do_wr       = wr_en && !full;
        do_rd       = rd_en && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_BITS'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_BITS'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_BITS'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = store_reg[rd_ptr_reg];
    assign full    = count_reg == CNT_BITS'(DEPTH);
    assign empty   = count_reg == '0;

endmodule

### hdl/qtd_back.sv
// ============================================================================
// Quad SPI decoder result side
// Steps through the frames of the oldest batch and presents them one at a time.
// ============================================================================
module qtd_back #(
    parameter int TIME_BITS = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  logic [1:0]                head_count,
    input  qtd_pkg::frame_t [1:0]     head_frame,
    input  logic [1:0][TIME_BITS-1:0] head_start,
    input  logic [1:0][TIME_BITS-1:0] head_end,
    input  logic                      pop,
    output logic                      head_release,
    output logic                      empty,
    output logic [2:0]                frame_kind,
    output logic [2:0]                error_code,
    output logic [31:0]               frame_value,
    output logic [7:0]                io1_byte,
    output logic [5:0]                bits_captured,
    output logic [TIME_BITS-1:0]      start_time,
    output logic [TIME_BITS-1:0]      end_time,
    output logic                      last_of_run
);

    logic            slot_reg, slot_next;
    logic            take;
    qtd_pkg::frame_t cur;

    always_comb
    begin
        cur           = head_frame[slot_reg];
        empty         = !head_valid;
        frame_kind    = cur.kind;
        error_code    = cur.code;
        frame_value   = cur.value;
        io1_byte      = cur.io1;
        bits_captured = cur.bits;
        start_time    = head_start[slot_reg];
        end_time      = head_end[slot_reg];
        last_of_run   = slot_reg || (head_count == 2'd1);
        take          = pop && head_valid;
        head_release  = take && last_of_run;
        slot_next     = slot_reg;
        if (take)
            slot_next = !last_of_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= 1'b0;
        else
            slot_reg <= slot_next;
    end

endmodule

### hdl/qtd_checker.sv
// ============================================================================
// Quad SPI decoder port checker
// Watches the result ports of the decoder over time.
// ============================================================================
module qtd_checker #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [2:0]           frame_kind,
    input  logic [2:0]           error_code,
    input  logic [31:0]          frame_value,
    input  logic [5:0]           bits_captured,
    input  logic [TIME_BITS-1:0] start_time,
    input  logic [TIME_BITS-1:0] end_time,
    input  logic                 last_of_run
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(frame_kind) && $stable(frame_value)
                           && $stable(start_time) && $stable(end_time))
        else $error("waiting frame changed before pop");

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> end_time != start_time)
        else $error("frame end equals start");

    a_event: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (frame_kind == qtd_pkg::KIND_ENABLE || frame_kind == qtd_pkg::KIND_DISABLE)
        |-> end_time == TIME_BITS'(start_time + TIME_BITS'(1)) && frame_value == 32'd0
            && bits_captured == 6'd0)
        else $error("malformed enable or disable frame");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_kind == qtd_pkg::KIND_ERROR) == (error_code != qtd_pkg::ERR_NONE))
        else $error("error code does not match frame kind");

    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_of_run |=> !empty)
        else $error("run ended without its final frame");

endmodule

bind qspi_transaction_decoder qtd_checker #(
    .TIME_BITS (TIME_BITS)
) u_qtd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .frame_kind    (frame_kind),
    .error_code    (error_code),
    .frame_value   (frame_value),
    .bits_captured (bits_captured),
    .start_time    (start_time),
    .end_time      (end_time),
    .last_of_run   (last_of_run)
);

### test/tb_qspi_transaction_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad SPI transaction decoder testbench
// Streams line snapshots of generated quad SPI transactions into the decoder,
// complete, truncated and noisy, under a sweep of register settings, and
// checks every frame against a behavioural predictor of the decoder.
// ============================================================================
module tb_qspi_transaction_decoder;

    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          RANDOM_SNAPSHOTS = 880;
    localparam int          SWEEP_ROUNDS     = 10;
    localparam int          DRAIN_SETTLE     = 4;
    localparam int          ADDR_MAX_BITS    = 32;
    localparam logic [1:0]  LANES_4          = 2'd2;
    localparam logic [1:0]  LANES_4_ALIAS    = 2'd3;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  code;
        logic [31:0] value;
        logic [7:0]  io1;
        logic [5:0]  bits;
        logic [47:0] t_start;
        logic [47:0] t_end;
        logic        last;
    } decoded_frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = qtd_pkg::REG_CS_ACTIVE;
    logic [5:0]  cfg_data = 6'd0;
    logic        push = 1'b0;
    logic        full;
    logic        cs_level = 1'b1;
    logic        clk_level = 1'b0;
    logic [3:0]  io_levels = 4'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  frame_kind;
    logic [2:0]  error_code;
    logic [31:0] frame_value;
    logic [7:0]  io1_byte;
    logic [5:0]  bits_captured;
    logic [47:0] start_time;
    logic [47:0] end_time;
    logic        last_of_run;

    logic [5:0]       shadow_regs [8];
    qtd_pkg::phase_t  dec_phase;
    logic             last_cs;
    logic             last_sclk;
    logic [31:0]      acc_value;
    logic [7:0]       acc_io1;
    logic [5:0]       acc_bits;
    logic [5:0]       acc_edges;
    logic [47:0]      sample_index;
    logic [47:0]      first_t;
    logic [47:0]      last_t;

    decoded_frame_t step_frames [$];
    decoded_frame_t pending_frames [$];

    int          mismatch_count = 0;
    int          frames_checked = 0;
    int          snapshots_sent = 0;
    int          settings_count = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;
    bit          steady_run = 1'b0;

    qspi_transaction_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .cs_level      (cs_level),
        .clk_level     (clk_level),
        .io_levels     (io_levels),
        .empty         (empty),
        .pop           (pop),
        .frame_kind    (frame_kind),
        .error_code    (error_code),
        .frame_value   (frame_value),
        .io1_byte      (io1_byte),
        .bits_captured (bits_captured),
        .start_time    (start_time),
        .end_time      (end_time),
        .last_of_run   (last_of_run)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[qspi_transaction_decoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned lanes_for(logic [1:0] code);
        if (code == qtd_pkg::LANES_1)
            return 1;
        if (code == qtd_pkg::LANES_2)
            return 2;
        return 4;
    endfunction

    function automatic int unsigned current_lanes();
        case (dec_phase)
            qtd_pkg::PH_CMD:  return lanes_for(shadow_regs[qtd_pkg::REG_CMD_LANES][1:0]);
            qtd_pkg::PH_ADDR: return lanes_for(shadow_regs[qtd_pkg::REG_ADDR_LANES][1:0]);
            default:          return lanes_for(shadow_regs[qtd_pkg::REG_DATA_LANES][1:0]);
        endcase
    endfunction

    function automatic int unsigned address_span();
        int unsigned n;
        int unsigned l;
        n = shadow_regs[qtd_pkg::REG_ADDR_BITS];
        l = lanes_for(shadow_regs[qtd_pkg::REG_ADDR_LANES][1:0]);
        if (n > ADDR_MAX_BITS)
            n = ADDR_MAX_BITS;
        return (n / l) * l;
    endfunction

    function automatic int unsigned word_target();
        int unsigned l;
        l = current_lanes();
        if (dec_phase == qtd_pkg::PH_ADDR)
            return address_span();
        return (qtd_pkg::WORD_BITS / l) * l;
    endfunction

    function automatic logic [47:0] word_end();
        return (last_t > first_t) ? last_t : first_t + 48'd1;
    endfunction

    function automatic void add_frame(logic [2:0] kind, logic [2:0] code, logic [31:0] value,
                                      logic [7:0] io1, logic [5:0] bits,
                                      logic [47:0] t0, logic [47:0] t1);
        decoded_frame_t f;
        f.kind = kind;
        f.code = code;
        f.value = value;
        f.io1 = io1;
        f.bits = bits;
        f.t_start = t0;
        f.t_end = t1;
        f.last = 1'b0;
        if (step_frames.size() < 2)
            step_frames.push_back(f);
    endfunction

    function automatic void start_phase(qtd_pkg::phase_t p);
        dec_phase = p;
        acc_value = '0;
        acc_io1 = '0;
        acc_bits = '0;
        acc_edges = '0;
    endfunction

    function automatic void leave_address();
        start_phase(shadow_regs[qtd_pkg::REG_DUMMY_CYCLES] != 0 ? qtd_pkg::PH_DUMMY
                                                                : qtd_pkg::PH_DATA);
    endfunction

    function automatic void leave_command();
        if (address_span() > 0)
            start_phase(qtd_pkg::PH_ADDR);
        else
            leave_address();
    endfunction

    function automatic void close_transaction(logic [47:0] t);
        add_frame(qtd_pkg::KIND_DISABLE, qtd_pkg::ERR_NONE, 32'd0, 8'd0, 6'd0, t, t + 48'd1);
        dec_phase = qtd_pkg::PH_IDLE;
    endfunction

    function automatic void flush_word(bit truncated);
        logic [2:0] kind;
        logic [2:0] code;
        case (dec_phase)
            qtd_pkg::PH_CMD:
            begin
                kind = qtd_pkg::KIND_COMMAND;
                code = qtd_pkg::ERR_TRUNC_CMD;
            end
            qtd_pkg::PH_ADDR:
            begin
                kind = qtd_pkg::KIND_ADDRESS;
                code = qtd_pkg::ERR_TRUNC_ADDR;
            end
            default:
            begin
                kind = qtd_pkg::KIND_DATA;
                code = qtd_pkg::ERR_TRUNC_DATA;
            end
        endcase
        if (acc_bits != 0)
            add_frame(truncated ? qtd_pkg::KIND_ERROR : kind,
                      truncated ? code : qtd_pkg::ERR_NONE, acc_value,
                      dec_phase == qtd_pkg::PH_DATA ? acc_io1 : 8'd0, acc_bits,
                      first_t, word_end());
    endfunction

    function automatic void shift_step(bit cs_edge, bit clk_edge, logic [3:0] io,
                                       logic [47:0] t);
        int unsigned lanes;
        int unsigned target;
        bit          trailing;
        bit          odd;
        logic [3:0]  lane_mask;
        lanes = current_lanes();
        target = word_target();
        trailing = shadow_regs[qtd_pkg::REG_TRAILING][0];
        lane_mask = 4'((1 << lanes) - 1);
        if (cs_edge)
        begin
            flush_word(!(!trailing && acc_edges[0] && acc_bits >= target));
            close_transaction(t);
            return;
        end
        if (!clk_edge)
            return;
        odd = acc_edges[0];
        acc_edges = acc_edges + 6'd1;
        if (trailing ? odd : !odd)
        begin
            if (acc_bits == 0)
                first_t = t;
            last_t = t;
            acc_value = (acc_value << lanes) | {28'd0, io & lane_mask};
            if (lanes == 1)
                acc_io1 = {acc_io1[6:0], io[1]};
            acc_bits = acc_bits + 6'(lanes);
        end
        if (odd && acc_bits >= target)
        begin
            flush_word(1'b0);
            if (dec_phase == qtd_pkg::PH_CMD)
                leave_command();
            else if (dec_phase == qtd_pkg::PH_ADDR)
                leave_address();
            else
                start_phase(qtd_pkg::PH_DATA);
        end
    endfunction

    function automatic void dummy_step(bit cs_edge, bit clk_edge, logic [47:0] t);
        if (cs_edge)
        begin
            if (acc_edges > 0)
                add_frame(qtd_pkg::KIND_ERROR, qtd_pkg::ERR_TRUNC_DUMMY,
                          {26'd0, shadow_regs[qtd_pkg::REG_DUMMY_CYCLES]},
                          8'd0, 6'd0, first_t, word_end());
            close_transaction(t);
            return;
        end
        if (!clk_edge)
            return;
        acc_edges = acc_edges + 6'd1;
        if (acc_edges == 1)
            first_t = t;
        last_t = t;
        if (int'(acc_edges) >= 2 * int'(shadow_regs[qtd_pkg::REG_DUMMY_CYCLES]))
        begin
            add_frame(qtd_pkg::KIND_DUMMY, qtd_pkg::ERR_NONE,
                      {26'd0, shadow_regs[qtd_pkg::REG_DUMMY_CYCLES]}, 8'd0, 6'd0,
                      first_t, word_end());
            start_phase(qtd_pkg::PH_DATA);
        end
    endfunction

    function automatic void decode_snapshot(logic cs, logic sclk, logic [3:0] io);
        logic [47:0] t;
        bit          cs_edge;
        bit          clk_edge;
        t = sample_index;
        cs_edge = (cs != last_cs);
        clk_edge = (sclk != last_sclk);
        step_frames.delete();
        case (dec_phase)
            qtd_pkg::PH_FIRST:
                dec_phase = (cs == shadow_regs[qtd_pkg::REG_CS_ACTIVE][0]) ? qtd_pkg::PH_SKIP
                                                                           : qtd_pkg::PH_IDLE;
            qtd_pkg::PH_SKIP:
                if (cs_edge)
                    dec_phase = qtd_pkg::PH_IDLE;
            qtd_pkg::PH_IDLE:
                if (cs_edge)
                begin
                    add_frame(qtd_pkg::KIND_ENABLE, qtd_pkg::ERR_NONE, 32'd0, 8'd0, 6'd0,
                              t, t + 48'd1);
                    if (sclk != shadow_regs[qtd_pkg::REG_CLK_IDLE][0])
                    begin
                        add_frame(qtd_pkg::KIND_ERROR, qtd_pkg::ERR_CLK_ACTIVE, 32'd0, 8'd0,
                                  6'd0, t, t + 48'd1);
                        dec_phase = qtd_pkg::PH_HOLD;
                    end
                    else
                        start_phase(qtd_pkg::PH_CMD);
                end
            qtd_pkg::PH_HOLD:
                if (cs_edge)
                    close_transaction(t);
            qtd_pkg::PH_DUMMY:
                dummy_step(cs_edge, clk_edge, t);
            default:
                shift_step(cs_edge, clk_edge, io, t);
        endcase
        last_cs = cs;
        last_sclk = sclk;
        sample_index = sample_index + 48'd1;
        if (step_frames.size() > 0)
            step_frames[step_frames.size() - 1].last = 1'b1;
        foreach (step_frames[i])
            pending_frames.push_back(step_frames[i]);
    endfunction

    function automatic void reset_predictor();
        foreach (shadow_regs[i])
            shadow_regs[i] = 6'd0;
        shadow_regs[qtd_pkg::REG_ADDR_BITS] = qtd_pkg::ADDR_BITS_RESET;
        dec_phase = qtd_pkg::PH_FIRST;
        last_cs = 1'b0;
        last_sclk = 1'b0;
        acc_value = '0;
        acc_io1 = '0;
        acc_bits = '0;
        acc_edges = '0;
        sample_index = '0;
        first_t = '0;
        last_t = '0;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    function automatic void compare_field(string field, logic [63:0] expected,
                                          logic [63:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, got %0h", field, expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            pop <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            pop <= steady_run || ($urandom_range(99) >= 29);
    end

    always @(posedge clk)
    begin : check_frames
        decoded_frame_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("frame with none expected: kind %0d, value %0h", frame_kind, frame_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                compare_field("frame_kind", want.kind, frame_kind);
                compare_field("error_code", want.code, error_code);
                compare_field("frame_value", want.value, frame_value);
                compare_field("io1_byte", want.io1, io1_byte);
                compare_field("bits_captured", want.bits, bits_captured);
                compare_field("start_time", want.t_start, start_time);
                compare_field("end_time", want.t_end, end_time);
                compare_field("last_of_run", want.last, last_of_run);
                frames_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drive side
    // ------------------------------------------------------------------
    task automatic send_sample(input logic cs, input logic sclk, input logic [3:0] io);
        while (!steady_run && $urandom_range(99) < 29)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        cs_level <= cs;
        clk_level <= sclk;
        io_levels <= io;
        do @(posedge clk); while (full);
        decode_snapshot(cs, sclk, io);
        snapshots_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [5:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            qtd_pkg::REG_CS_ACTIVE, qtd_pkg::REG_CLK_IDLE, qtd_pkg::REG_TRAILING:
                shadow_regs[index] = value & 6'd1;
            qtd_pkg::REG_CMD_LANES, qtd_pkg::REG_ADDR_LANES, qtd_pkg::REG_DATA_LANES:
                shadow_regs[index] = value & 6'd3;
            qtd_pkg::REG_DUMMY_CYCLES:
                shadow_regs[index] = value & 6'd31;
            default:
                shadow_regs[index] = value;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic cs_active, input logic clk_idle,
                                  input logic trailing, input logic [1:0] cmd_lanes,
                                  input logic [5:0] addr_bits, input logic [1:0] addr_lanes,
                                  input logic [4:0] dummy, input logic [1:0] data_lanes);
        write_register(qtd_pkg::REG_CS_ACTIVE, {5'd0, cs_active});
        write_register(qtd_pkg::REG_CLK_IDLE, {5'd0, clk_idle});
        write_register(qtd_pkg::REG_TRAILING, {5'd0, trailing});
        write_register(qtd_pkg::REG_CMD_LANES, {4'd0, cmd_lanes});
        write_register(qtd_pkg::REG_ADDR_BITS, addr_bits);
        write_register(qtd_pkg::REG_ADDR_LANES, {4'd0, addr_lanes});
        write_register(qtd_pkg::REG_DUMMY_CYCLES, {1'b0, dummy});
        write_register(qtd_pkg::REG_DATA_LANES, {4'd0, data_lanes});
        settings_count++;
    endtask

    task automatic spi_transaction(input int unsigned edges, input bit bad_clock,
                                   input bit live_write);
        logic        active;
        logic        sclk;
        int unsigned k;
        active = shadow_regs[qtd_pkg::REG_CS_ACTIVE][0];
        sclk = shadow_regs[qtd_pkg::REG_CLK_IDLE][0];
        repeat ($urandom_range(1, 2)) send_sample(!active, 1'($urandom), 4'($urandom));
        if (bad_clock)
            sclk = !sclk;
        repeat ($urandom_range(1, 2)) send_sample(active, sclk, 4'($urandom));
        for (k = 0; k < edges; k++)
        begin
            if (live_write && k == edges / 2)
            begin
                wait_for_drain();
                write_register(3'($urandom_range(qtd_pkg::REG_TRAILING,
                                                 qtd_pkg::REG_DATA_LANES)), 6'($urandom));
            end
            sclk = !sclk;
            repeat ($urandom_range(99) < 60 ? 1 : $urandom_range(2, 3))
                send_sample(active, sclk, 4'($urandom));
        end
        // toggle the clock alongside the deassert now and then
        if ($urandom_range(3) == 0)
            sclk = !sclk;
        send_sample(!active, sclk, 4'($urandom));
    endtask

    task automatic random_transaction();
        int unsigned cycles;
        int unsigned edges;
        int unsigned pick;
        int unsigned lc;
        int unsigned la;
        int unsigned ld;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            repeat ($urandom_range(1, 4)) send_sample(1'($urandom), 1'($urandom), 4'($urandom));
            return;
        end
        lc = lanes_for(shadow_regs[qtd_pkg::REG_CMD_LANES][1:0]);
        la = lanes_for(shadow_regs[qtd_pkg::REG_ADDR_LANES][1:0]);
        ld = lanes_for(shadow_regs[qtd_pkg::REG_DATA_LANES][1:0]);
        cycles = 8 / lc + address_span() / la + shadow_regs[qtd_pkg::REG_DUMMY_CYCLES]
                 + $urandom_range(1, 3) * (8 / ld);
        edges = 2 * cycles;
        case ($urandom_range(99) / 15)
            6:       edges = $urandom_range(0, edges);
            5:       edges = edges - 1;
            default: ;
        endcase
        spi_transaction(edges, pick < 12, $urandom_range(99) < 8);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_skip_and_clock_error();
        send_sample(1'b0, 1'b0, 4'h0);
        send_sample(1'b0, 1'b1, 4'hF);
        send_sample(1'b1, 1'b0, 4'h0);
        send_sample(1'b0, 1'b1, 4'h5);
        send_sample(1'b0, 1'b0, 4'hA);
        send_sample(1'b1, 1'b0, 4'hF);
    endtask

    task automatic test_quad_word();
        wait_for_drain();
        apply_settings(1'b0, 1'b0, 1'b0, LANES_4, 6'd0, qtd_pkg::LANES_1, 5'd0, LANES_4);
        send_sample(1'b0, 1'b0, 4'h3);
        send_sample(1'b0, 1'b1, 4'hF);
        send_sample(1'b0, 1'b0, 4'h0);
        send_sample(1'b0, 1'b1, 4'h0);
        send_sample(1'b0, 1'b0, 4'h0);
        send_sample(1'b0, 1'b1, 4'h0);
        send_sample(1'b0, 1'b0, 4'hF);
        send_sample(1'b0, 1'b1, 4'hF);
        send_sample(1'b0, 1'b0, 4'h0);
        send_sample(1'b1, 1'b0, 4'h0);
    endtask

    task automatic test_config_sweep();
        int round;
        int goal;
        int base;
        base = snapshots_sent;
        for (round = 0; round < SWEEP_ROUNDS; round++)
        begin
            wait_for_drain();
            case (round)
                0: apply_settings(1'b0, 1'b0, 1'b0, qtd_pkg::LANES_1, 6'd0, qtd_pkg::LANES_1,
                                  5'd0, qtd_pkg::LANES_1);
                1: apply_settings(1'b1, 1'b1, 1'b1, LANES_4_ALIAS, 6'd63, LANES_4_ALIAS,
                                  5'd31, LANES_4_ALIAS);
                2: apply_settings(1'b0, 1'b1, 1'b1, qtd_pkg::LANES_2, 6'd24, qtd_pkg::LANES_2,
                                  5'd2, qtd_pkg::LANES_1);
                3: apply_settings(1'b1, 1'b0, 1'b0, LANES_4, 6'd32, LANES_4, 5'd8, LANES_4);
                default:
                    apply_settings(1'($urandom), 1'($urandom), 1'($urandom),
                                   2'($urandom_range(3)),
                                   ($urandom_range(1) == 0) ? 6'($urandom_range(1, 4) * 8)
                                                            : 6'($urandom),
                                   2'($urandom_range(3)),
                                   ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3)),
                                   2'($urandom_range(3)));
            endcase
            steady_run = (round == 4);
            goal = base + (round + 1) * RANDOM_SNAPSHOTS / SWEEP_ROUNDS;
            do
                random_transaction();
            while (snapshots_sent < goal);
        end
        steady_run = 1'b0;
    endtask

    task automatic test_backpressure();
        logic active;
        int   k;
        wait_for_drain();
        active = shadow_regs[qtd_pkg::REG_CS_ACTIVE][0];
        hold_cycles = 250;
        for (k = 0; k < 48; k++)
            send_sample(k[0] ? active : !active, shadow_regs[qtd_pkg::REG_CLK_IDLE][0],
                        4'($urandom));
        wait_for_drain();
    endtask

    initial
    begin
        reset_predictor();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_skip_and_clock_error();
        test_quad_word();
        test_config_sweep();
        test_backpressure();
        wait_for_drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d snapshots and %0d frames over %0d register settings,",
                 snapshots_sent, frames_checked, settings_count);
        $display("with skipped starts, clock errors, truncation, back-pressure and live writes.");
        if (mismatch_count == 0 && pending_frames.size() == 0)
            $display("[qspi_transaction_decoder] OK");
        else
            $display("[qspi_transaction_decoder] ERROR");
        $finish;
    end

endmodule
